// ----- rtl/drrip_pkg.sv -----
// drrip_pkg: shared constants, codes and types for the DRRIP replacement block.
// No dependencies; used by drrip_ctrl, drrip_dp, drrip_replacement_policy, drrip_checker and tb.
package drrip_pkg;

    localparam int NUM_SETS       = 2048;
    localparam int SET_W          = $clog2(NUM_SETS);
    localparam int SET_PORT_W     = 11;
    localparam int NUM_WAYS       = 16;
    localparam int WAY_W          = 4;
    localparam int RRPV_LIMIT     = 7;
    localparam int RRPV_W         = $clog2(RRPV_LIMIT + 1);
    localparam int ROW_W          = NUM_WAYS * RRPV_W;
    localparam int SELECTOR_LIMIT = 127;
    localparam int SEL_W          = 7;
    localparam int SEL_MID        = SELECTOR_LIMIT / 2;
    localparam int LFSR_W         = 16;
    localparam int ROLE_W         = 2;
    localparam int OP_W           = 2;

    localparam logic [LFSR_W-1:0] LFSR_SEED    = 16'hACE1;
    localparam logic [LFSR_W-1:0] CHANCE_RESET = 16'd6554;

    localparam logic [RRPV_W-1:0] RRPV_TOP      = RRPV_W'(RRPV_LIMIT);
    localparam logic [RRPV_W-1:0] RRPV_DISTANT  = RRPV_W'(RRPV_LIMIT - 1);
    localparam logic [RRPV_W-1:0] RRPV_NEAR     = RRPV_W'(RRPV_LIMIT - 2);
    localparam logic [ROW_W-1:0]  ROW_RESET     = {NUM_WAYS{RRPV_TOP}};

    typedef enum logic [OP_W-1:0] {
        OP_VICTIM = 2'd0,
        OP_UPDATE = 2'd1,
        OP_ROLE   = 2'd2
    } opcode_t;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_FOLLOWER = 2'd0,
        ROLE_SRRIP    = 2'd1,
        ROLE_BRRIP    = 2'd2
    } role_t;

    typedef struct packed {
        logic             capture;
        logic             commit;
        logic             clear_we;
        logic [SET_W-1:0] clear_addr;
    } cmd_t;

endpackage

// ----- rtl/drrip_ram.sv -----
// drrip_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module drrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/drrip_ctrl.sv -----
// drrip_ctrl: sequencer for the DRRIP block (post-reset clear sweep, read, modify-write).
// Depends on drrip_pkg; drives the drrip_dp command struct.
module drrip_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output drrip_pkg::cmd_t cmd
);
    import drrip_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY
    } state_t;

    state_t           state_reg, state_next;
    logic [SET_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             commit;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign commit   = (state_reg == ST_MODIFY) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cmd.capture    = accept;
    assign cmd.commit     = commit;
    assign cmd.clear_we   = (state_reg == ST_CLEAR);
    assign cmd.clear_addr = clear_cnt_reg;

endmodule

// ----- rtl/drrip_dp.sv -----
// drrip_dp: DRRIP datapath - RRPV row and role memories, victim search, ageing,
// insertion, policy selector and LFSR. Depends on drrip_pkg and drrip_ram.
module drrip_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  drrip_pkg::cmd_t                      cmd,
    input  logic [drrip_pkg::OP_W-1:0]           opcode,
    input  logic [drrip_pkg::SET_PORT_W-1:0]     set_index,
    input  logic [drrip_pkg::WAY_W-1:0]          way_index,
    input  logic                                 is_writeback,
    input  logic                                 is_hit,
    input  logic [drrip_pkg::ROLE_W-1:0]         role_value,
    input  logic                                 cfg_we,
    input  logic [drrip_pkg::LFSR_W-1:0]         cfg_wdata,
    output logic [drrip_pkg::WAY_W-1:0]          victim_way,
    output logic                                 follow_brrip,
    output logic [drrip_pkg::SEL_W-1:0]          selector_value
);
    import drrip_pkg::*;

    // captured item
    logic [OP_W-1:0]   op_reg;
    logic [SET_W-1:0]  set_reg;
    logic [WAY_W-1:0]  way_reg;
    logic              wb_reg;
    logic              hit_reg;
    logic [ROLE_W-1:0] role_in_reg;

    // policy state
    logic [SEL_W-1:0]  selector_reg, selector_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [LFSR_W-1:0] chance_reg;

    // result
    logic [WAY_W-1:0]  victim_reg;
    logic              follow_reg;
    logic [SEL_W-1:0]  sel_out_reg;

    // memories
    logic [SET_W-1:0]  raddr;
    logic [SET_W-1:0]  waddr;
    logic              row_we;
    logic [ROW_W-1:0]  row_wdata;
    logic [ROW_W-1:0]  rd_row;
    logic              role_we;
    logic [ROLE_W-1:0] role_wdata;
    logic [ROLE_W-1:0] rd_role;

    // victim search and update
    logic [NUM_WAYS-1:0] cand;
    logic [RRPV_W-1:0]   top;
    logic [WAY_W-1:0]    victim;
    logic [RRPV_W-1:0]   age_add;
    logic [ROW_W-1:0]    aged_row;
    logic [ROW_W-1:0]    upd_row;
    logic [RRPV_W-1:0]   upd_val;
    logic                lfsr_fb;
    logic [LFSR_W-1:0]   lfsr_step;
    logic [RRPV_W-1:0]   brrip_val;
    logic                lfsr_adv;
    logic [SEL_W-1:0]    sel_up;
    logic [SEL_W-1:0]    sel_dn;
    logic [SEL_W-1:0]    sel_final;
    logic [ROLE_W-1:0]   role_store;

    assign raddr = cmd.capture ? set_index[SET_W-1:0] : set_reg;
    assign waddr = cmd.clear_we ? cmd.clear_addr : set_reg;

    drrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_rrpv_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (waddr),
        .wdata (row_wdata),
        .raddr (raddr),
        .rdata (rd_row)
    );

    drrip_ram #(
        .WIDTH (ROLE_W),
        .DEPTH (NUM_SETS)
    ) u_role_ram (
        .clk   (clk),
        .we    (role_we),
        .waddr (waddr),
        .wdata (role_wdata),
        .raddr (raddr),
        .rdata (rd_role)
    );

    // max search, MSB first; cand ends as the ways that hold the maximum
    always_comb
    begin
        logic any;
        any  = 1'b0;
        cand = '1;
        top  = '0;
        for (int b = RRPV_W - 1; b >= 0; b--)
        begin
            any = 1'b0;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                any = any | (cand[w] & rd_row[w*RRPV_W + b]);
            end
            top[b] = any;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (any && !rd_row[w*RRPV_W + b])
                begin
                    cand[w] = 1'b0;
                end
            end
        end
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (cand[w])
            begin
                victim = WAY_W'(w);
            end
        end
    end

    assign age_add = RRPV_TOP - top;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged_row[w*RRPV_W +: RRPV_W] = rd_row[w*RRPV_W +: RRPV_W] + age_add;
        end
    end

    // Fibonacci LFSR, taps 16,14,13,11
    assign lfsr_fb   = lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5];
    assign lfsr_step = {lfsr_fb, lfsr_reg[LFSR_W-1:1]};
    assign brrip_val = (lfsr_step < chance_reg) ? RRPV_NEAR : RRPV_DISTANT;

    assign sel_up = (selector_reg == SEL_W'(SELECTOR_LIMIT)) ? selector_reg
                                                            : selector_reg + 1'b1;
    assign sel_dn = (selector_reg == '0) ? selector_reg : selector_reg - 1'b1;

    always_comb
    begin
        selector_next = selector_reg;
        lfsr_adv      = 1'b0;
        upd_val       = RRPV_NEAR;
        if (wb_reg)
        begin
            upd_val = RRPV_DISTANT;
        end
        else if (hit_reg)
        begin
            upd_val = '0;
            if (rd_role == ROLE_BRRIP)
            begin
                selector_next = sel_up;
            end
            else if (rd_role == ROLE_SRRIP)
            begin
                selector_next = sel_dn;
            end
        end
        else if (rd_role == ROLE_BRRIP)
        begin
            selector_next = sel_dn;
            lfsr_adv      = 1'b1;
            upd_val       = brrip_val;
        end
        else if (rd_role == ROLE_SRRIP)
        begin
            selector_next = sel_up;
        end
        else if (selector_reg > SEL_W'(SEL_MID))
        begin
            lfsr_adv = 1'b1;
            upd_val  = brrip_val;
        end
    end

    always_comb
    begin
        upd_row = rd_row;
        if (int'(way_reg) < NUM_WAYS)
        begin
            upd_row[way_reg*RRPV_W +: RRPV_W] = upd_val;
        end
    end

    always_comb
    begin
        case (role_in_reg)
            ROLE_SRRIP: role_store = ROLE_SRRIP;
            ROLE_BRRIP: role_store = ROLE_BRRIP;
            default:    role_store = ROLE_FOLLOWER;
        endcase
    end

    assign sel_final = (op_reg == OP_UPDATE) ? selector_next : selector_reg;
    assign lfsr_next = (op_reg == OP_UPDATE && lfsr_adv) ? lfsr_step : lfsr_reg;

    assign row_we     = cmd.clear_we
                     || (cmd.commit && (op_reg == OP_VICTIM || op_reg == OP_UPDATE));
    assign row_wdata  = cmd.clear_we ? ROW_RESET
                      : ((op_reg == OP_VICTIM) ? aged_row : upd_row);
    assign role_we    = cmd.clear_we || (cmd.commit && op_reg == OP_ROLE);
    assign role_wdata = cmd.clear_we ? ROLE_FOLLOWER : role_store;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= opcode;
            set_reg     <= set_index[SET_W-1:0];
            way_reg     <= way_index;
            wb_reg      <= is_writeback;
            hit_reg     <= is_hit;
            role_in_reg <= role_value;
        end
        if (cmd.commit)
        begin
            victim_reg  <= (op_reg == OP_VICTIM) ? victim : '0;
            sel_out_reg <= sel_final;
            follow_reg  <= (sel_final > SEL_W'(SEL_MID));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            selector_reg <= SEL_W'(SEL_MID);
            lfsr_reg     <= LFSR_SEED;
            chance_reg   <= CHANCE_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                selector_reg <= sel_final;
                lfsr_reg     <= lfsr_next;
            end
            if (cfg_we)
            begin
                chance_reg <= cfg_wdata;
            end
        end
    end

    assign victim_way     = victim_reg;
    assign follow_brrip   = follow_reg;
    assign selector_value = sel_out_reg;

endmodule

// ----- rtl/drrip_replacement_policy.sv -----
// DRRIP cache replacement policy, 3-bit RRPV per way, set dueling selector.
// Usage:
//   Input channel (in_valid/in_ready) carries one item: opcode, set_index,
//   way_index, is_writeback, is_hit, role_value. Opcode 0 finds a victim
//   (ageing the set if needed), 1 updates a way on hit/fill/writeback,
//   2 loads the set role.
//   Output channel (out_valid/out_ready) returns one item per input item:
//   victim_way (0 unless victim request), follow_brrip, selector_value.
//   Each item reads its set row from RAM, then modifies and writes it back:
//   the result is registered after the modify step, and a new item is taken
//   only once the previous item has left the modify step.
//   If the output is stalled, the next item is still accepted and held in
//   the modify step until the pending result is taken.
//   After reset a clear sweep writes all 2048 sets; in_ready stays low until
//   it finishes. cfg_we/cfg_wdata write brrip_chance at any time; write it
//   only while idle.
// Depends on drrip_pkg, drrip_ctrl, drrip_dp, drrip_ram.
module drrip_replacement_policy (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [drrip_pkg::OP_W-1:0]           opcode,
    input  logic [drrip_pkg::SET_PORT_W-1:0]     set_index,
    input  logic [drrip_pkg::WAY_W-1:0]          way_index,
    input  logic                                 is_writeback,
    input  logic                                 is_hit,
    input  logic [drrip_pkg::ROLE_W-1:0]         role_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [drrip_pkg::WAY_W-1:0]          victim_way,
    output logic                                 follow_brrip,
    output logic [drrip_pkg::SEL_W-1:0]          selector_value,
    input  logic                                 cfg_we,
    input  logic [drrip_pkg::LFSR_W-1:0]         cfg_wdata
);
    import drrip_pkg::*;

    cmd_t cmd;

    drrip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    drrip_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .opcode         (opcode),
        .set_index      (set_index),
        .way_index      (way_index),
        .is_writeback   (is_writeback),
        .is_hit         (is_hit),
        .role_value     (role_value),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .victim_way     (victim_way),
        .follow_brrip   (follow_brrip),
        .selector_value (selector_value)
    );

endmodule

// ----- rtl/drrip_checker.sv -----
// drrip_checker: port-level assertions for drrip_replacement_policy, bound to the top.
// Depends on drrip_pkg.
module drrip_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [drrip_pkg::WAY_W-1:0]          victim_way,
    input logic                                 follow_brrip,
    input logic [drrip_pkg::SEL_W-1:0]          selector_value
);
    import drrip_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(victim_way)
            && $stable(follow_brrip) && $stable(selector_value))
        else $error("result changed while stalled");

    // one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item in modify step");

    // fresh result comes after its item passes the modify step and the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching item");

    a_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> follow_brrip == (selector_value > SEL_W'(SEL_MID)))
        else $error("follow_brrip disagrees with selector");

endmodule

bind drrip_replacement_policy drrip_checker u_drrip_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .victim_way     (victim_way),
    .follow_brrip   (follow_brrip),
    .selector_value (selector_value)
);

// ----- tb/tb.sv -----
// Self-checking testbench for drrip_replacement_policy (DRRIP, 3-bit RRPV per way).
// Keeps its own copy of the RRPV rows, set roles, selector and LFSR to predict each item.
// Depends on drrip_pkg and the RTL under rtl/.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import drrip_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
    localparam logic [ROLE_W-1:0] ROLE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 10000;
    localparam int HOT_SETS    = 16;

    typedef enum int {PUSH_UP, PUSH_DOWN, PUSH_MIXED} push_t;

    typedef struct {
        logic [OP_W-1:0]       op;
        logic [SET_PORT_W-1:0] set_idx;
        logic [WAY_W-1:0]      way_idx;
        logic                  wb;
        logic                  hit;
        logic [ROLE_W-1:0]     role;
    } access_t;

    typedef struct {
        logic [WAY_W-1:0] victim;
        logic             follow;
        logic [SEL_W-1:0] sel;
    } outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       opcode = '0;
    logic [SET_PORT_W-1:0] set_index = '0;
    logic [WAY_W-1:0]      way_index = '0;
    logic                  is_writeback = 1'b0;
    logic                  is_hit = 1'b0;
    logic [ROLE_W-1:0]     role_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic [WAY_W-1:0]      victim_way;
    logic                  follow_brrip;
    logic [SEL_W-1:0]      selector_value;
    logic                  cfg_we = 1'b0;
    logic [LFSR_W-1:0]     cfg_wdata = '0;

    // predicted block state
    logic [RRPV_W-1:0] rrpv_state [NUM_SETS][NUM_WAYS];
    role_t             role_state [NUM_SETS];
    logic [SEL_W-1:0]  psel;
    logic [LFSR_W-1:0] lfsr;
    logic [LFSR_W-1:0] chance;

    outcome_t              outcome_q [$];
    logic [SET_PORT_W-1:0] hot_sets [HOT_SETS];
    int                    err_count = 0;
    int                    burst_left = 0;
    bit                    tx_idle = 1'b1;
    bit                    rx_stalls = 1'b1;
    int                    ready_left = 0;
    int                    quiet_cycles = 0;

    drrip_replacement_policy dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .set_index      (set_index),
        .way_index      (way_index),
        .is_writeback   (is_writeback),
        .is_hit         (is_hit),
        .role_value     (role_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .victim_way     (victim_way),
        .follow_brrip   (follow_brrip),
        .selector_value (selector_value),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [RRPV_W-1:0] brrip_value();
        logic fb;
        fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
        lfsr = {fb, lfsr[LFSR_W-1:1]};
        return (lfsr < chance) ? RRPV_NEAR : RRPV_DISTANT;
    endfunction

    function automatic logic [SEL_W-1:0] sel_up(logic [SEL_W-1:0] s);
        return (s < SELECTOR_LIMIT) ? s + 1'b1 : s;
    endfunction

    function automatic logic [SEL_W-1:0] sel_down(logic [SEL_W-1:0] s);
        return (s > 0) ? s - 1'b1 : s;
    endfunction

    // advances the predicted state by one item and returns the expected result
    function automatic outcome_t apply_access(access_t it);
        outcome_t          res;
        int                s;
        logic [RRPV_W-1:0] top;
        logic [RRPV_W-1:0] val;
        role_t             r;
        s = it.set_idx % NUM_SETS;
        res.victim = '0;
        if (it.op == OP_VICTIM)
        begin
            top = '0;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (rrpv_state[s][w] > top)
                begin
                    top = rrpv_state[s][w];
                    res.victim = WAY_W'(w);
                end
            end
            if (top < RRPV_TOP)
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                    rrpv_state[s][w] = rrpv_state[s][w] + (RRPV_TOP - top);
            end
        end
        else if (it.op == OP_UPDATE)
        begin
            r = role_state[s];
            if (it.wb)
                val = RRPV_DISTANT;
            else if (it.hit)
            begin
                val = '0;
                if (r == ROLE_BRRIP)
                    psel = sel_up(psel);
                else if (r == ROLE_SRRIP)
                    psel = sel_down(psel);
            end
            else if (r == ROLE_BRRIP)
            begin
                psel = sel_down(psel);
                val = brrip_value();
            end
            else if (r == ROLE_SRRIP)
            begin
                psel = sel_up(psel);
                val = RRPV_NEAR;
            end
            else if (psel > SEL_MID)
                val = brrip_value();
            else
                val = RRPV_NEAR;
            if (it.way_idx < NUM_WAYS)
                rrpv_state[s][it.way_idx] = val;
        end
        else if (it.op == OP_ROLE)
        begin
            if (it.role == ROLE_UNUSED)
                role_state[s] = ROLE_FOLLOWER;
            else
                role_state[s] = role_t'(it.role);
        end
        res.follow = (psel > SEL_MID);
        res.sel = psel;
        return res;
    endfunction

    function automatic access_t mk_access(int op, int s, int w, int wb, int hit, int role);
        access_t it;
        it.op = OP_W'(op);
        it.set_idx = SET_PORT_W'(s);
        it.way_idx = WAY_W'(w);
        it.wb = 1'(wb);
        it.hit = 1'(hit);
        it.role = ROLE_W'(role);
        return it;
    endfunction

    // send one item, in bursts with random gaps while tx_idle is set; valid stays high after acceptance
    task automatic issue(access_t it);
        if (burst_left == 0)
        begin
            if (tx_idle)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid     <= 1'b1;
        opcode       <= it.op;
        set_index    <= it.set_idx;
        way_index    <= it.way_idx;
        is_writeback <= it.wb;
        is_hit       <= it.hit;
        role_value   <= it.role;
        do @(posedge clk); while (!in_ready);
        outcome_q = {outcome_q, apply_access(it)};
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (outcome_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_chance(logic [LFSR_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        chance = v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // hit/miss choice that drives the selector the wanted way in leader sets
    function automatic logic steer_hit(logic [SET_PORT_W-1:0] s, push_t p);
        if (p == PUSH_MIXED || role_state[s] == ROLE_FOLLOWER || $urandom_range(0, 9) == 0)
            return 1'($urandom_range(0, 1));
        if (p == PUSH_UP)
            return role_state[s] == ROLE_BRRIP;
        return role_state[s] == ROLE_SRRIP;
    endfunction

    task automatic random_traffic(int count, push_t p);
        int                    sent;
        int                    pick;
        logic [SET_PORT_W-1:0] hs;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            hs = hot_sets[$urandom_range(0, HOT_SETS - 1)];
            if (pick < 6)
            begin
                // fill every way, then ask for a victim: forces set ageing
                for (int w = 0; w < NUM_WAYS; w++)
                    issue(mk_access(OP_UPDATE, hs, w, $urandom_range(0, 7) == 0,
                                    steer_hit(hs, p), $urandom_range(0, 3)));
                issue(mk_access(OP_VICTIM, hs, $urandom_range(0, 15), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 3)));
                sent += NUM_WAYS + 1;
            end
            else
            begin
                if (pick < 12)
                    issue(mk_access(OP_ROLE, hs, $urandom_range(0, 15), $urandom_range(0, 1),
                                    $urandom_range(0, 1), $urandom_range(0, 3)));
                else if (pick < 30)
                    issue(mk_access(OP_VICTIM, hs, $urandom_range(0, 15), $urandom_range(0, 1),
                                    $urandom_range(0, 1), $urandom_range(0, 3)));
                else if (pick < 38)
                    issue(mk_access($urandom_range(0, 3), $urandom_range(0, NUM_SETS - 1),
                                    $urandom_range(0, 15), $urandom_range(0, 1),
                                    $urandom_range(0, 1), $urandom_range(0, 3)));
                else
                    issue(mk_access(OP_UPDATE, hs, $urandom_range(0, 15),
                                    $urandom_range(0, 7) == 0, steer_hit(hs, p),
                                    $urandom_range(0, 3)));
                sent++;
            end
        end
    endtask

    task automatic test_reset_state();
        issue(mk_access(OP_VICTIM, 0, 0, 1'b0, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_VICTIM, NUM_SETS - 1, 15, 1'b1, 1'b1, ROLE_UNUSED));
        issue(mk_access(OP_UNUSED, NUM_SETS - 1, 15, 1'b1, 1'b1, ROLE_UNUSED));
        issue(mk_access(OP_ROLE, NUM_SETS - 1, 0, 1'b0, 1'b0, ROLE_UNUSED));
        drain();
    endtask

    task automatic test_update_rules();
        issue(mk_access(OP_UPDATE, 0, 15, 1'b0, 1'b1, ROLE_FOLLOWER));
        issue(mk_access(OP_UPDATE, 0, 0, 1'b1, 1'b1, ROLE_FOLLOWER));
        issue(mk_access(OP_VICTIM, 0, 0, 1'b0, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_ROLE, 5, 0, 1'b0, 1'b0, ROLE_SRRIP));
        issue(mk_access(OP_ROLE, 6, 0, 1'b0, 1'b0, ROLE_BRRIP));
        issue(mk_access(OP_UPDATE, 5, 2, 1'b0, 1'b1, ROLE_FOLLOWER));
        issue(mk_access(OP_UPDATE, 6, 3, 1'b0, 1'b1, ROLE_FOLLOWER));
        issue(mk_access(OP_UPDATE, 6, 4, 1'b0, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_UPDATE, 5, 5, 1'b0, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_UPDATE, 5, 6, 1'b0, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_UPDATE, 0, 7, 1'b0, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_UPDATE, 6, 9, 1'b0, 1'b1, ROLE_FOLLOWER));
        issue(mk_access(OP_UPDATE, 6, 10, 1'b1, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_ROLE, 5, 0, 1'b0, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_UPDATE, 5, 8, 1'b0, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_VICTIM, 5, 0, 1'b0, 1'b0, ROLE_FOLLOWER));
        issue(mk_access(OP_VICTIM, 6, 0, 1'b0, 1'b0, ROLE_FOLLOWER));
        drain();
    endtask

    task automatic test_brrip_chance();
        set_chance('0);
        random_traffic(200, PUSH_UP);
        drain();
        set_chance('1);
        random_traffic(200, PUSH_MIXED);
        drain();
    endtask

    task automatic test_selector_saturation();
        int n;
        set_chance(LFSR_W'($urandom_range(0, 65535)));
        for (int i = 2; i < 6; i++)
            issue(mk_access(OP_ROLE, hot_sets[i], 0, 1'b0, 1'b0, ROLE_SRRIP));
        for (int i = 6; i < 10; i++)
            issue(mk_access(OP_ROLE, hot_sets[i], 0, 1'b0, 1'b0, ROLE_BRRIP));
        tx_idle = 1'b0;
        rx_stalls = 1'b0;
        n = 0;
        while (psel != SELECTOR_LIMIT && n < 800)
        begin
            random_traffic(50, PUSH_UP);
            n += 50;
        end
        tx_idle = 1'b1;
        rx_stalls = 1'b1;
        random_traffic(60, PUSH_UP);
        n = 0;
        while (psel != 0 && n < 800)
        begin
            random_traffic(50, PUSH_DOWN);
            n += 50;
        end
        random_traffic(60, PUSH_DOWN);
        drain();
    endtask

    task automatic test_mixed_traffic();
        set_chance(CHANCE_RESET);
        random_traffic(300, PUSH_MIXED);
        drain();
    endtask

    initial
    begin
        for (int s = 0; s < NUM_SETS; s++)
        begin
            role_state[s] = ROLE_FOLLOWER;
            for (int w = 0; w < NUM_WAYS; w++)
                rrpv_state[s][w] = RRPV_TOP;
        end
        psel = SEL_W'(SEL_MID);
        lfsr = LFSR_SEED;
        chance = CHANCE_RESET;
        hot_sets[0] = '0;
        hot_sets[1] = '1;
        for (int i = 2; i < HOT_SETS; i++)
            hot_sets[i] = SET_PORT_W'($urandom_range(1, NUM_SETS - 2));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_update_rules();
        test_brrip_chance();
        test_selector_saturation();
        test_mixed_traffic();

        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // result checker and receiver stall pattern
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result with no item outstanding");
                err_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (victim_way !== want.victim)
                begin
                    $error("victim_way expected %0d actual %0d", want.victim, victim_way);
                    err_count++;
                end
                if (follow_brrip !== want.follow)
                begin
                    $error("follow_brrip expected %0d actual %0d", want.follow, follow_brrip);
                    err_count++;
                end
                if (selector_value !== want.sel)
                begin
                    $error("selector_value expected %0d actual %0d", want.sel, selector_value);
                    err_count++;
                end
            end
        end
        if (!rx_stalls)
            out_ready <= 1'b1;
        else if (ready_left == 0)
        begin
            if (out_ready)
                ready_left = $urandom_range(1, 6);
            else
                ready_left = $urandom_range(1, 16);
            out_ready <= !out_ready;
        end
        else
            ready_left--;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
